// File: rtl/ddo_pkg.sv
package ddo_pkg;

  typedef struct packed {
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
  } ddo_in_t;

  typedef struct packed {
    logic signed [47:0] x_pos;
    logic signed [47:0] y_pos;
    logic        [31:0] heading;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
  } ddo_out_t;

  localparam int CordicIters = 24;
  localparam int PosFracBits = 24;
  localparam int PosShift    = 63 - PosFracBits;
  localparam int MagBits     = 80 - PosShift;

  localparam logic signed [33:0] CordicX0 = 34'sh026DD3B6A;

  typedef enum logic [7:0] {
    CfgMetersPerPulse = 8'd0,
    CfgMinCount       = 8'd1,
    CfgMaxCount       = 8'd2,
    CfgTurnGain       = 8'd3
  } ddo_cfg_e;

  typedef enum logic [3:0] {
    StIdle, StMulSd, StMulHd, StCord1, StFin1, StMulSum, StMulX, StMulY,
    StYUpd, StCord2, StFin2, StDone
  } ddo_state_e;

  // Arctangent of 2^-k in binary-angle units (2^32 is a full turn).
  function automatic logic [31:0] ddo_atan(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/differential_drive_odometry.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_data_i   (ddo_in_t)
// out       output     out_valid_o / out_ready_i  out_data_o  (ddo_out_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A shift-add multiplier that retires one multiplier bit per cycle runs five products, and a
// single CORDIC stage runs 24 iterations twice. The sequencer takes no new input until the
// previous result has been loaded into the output register.
// Reset clears the odometry state and loads the register defaults; no clearing pass.
// A finished result waits in the output register; a new input transaction is taken
// as soon as the sequencer is idle, and only the final load waits on a stalled output.
module differential_drive_odometry
  import ddo_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ddo_in_t        in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ddo_out_t       out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_index_i,
  input  logic [39:0]    cfg_data_i
);

  // Configuration registers.
  logic [31:0] mpp_q;
  logic [15:0] min_q, max_q;
  logic [39:0] tg_q;

  // Odometry state.
  logic [31:0] lprev_q, lprev_d, rprev_q, rprev_d, heading_q, heading_d;
  logic signed [47:0] xacc_q, xacc_d, yacc_q, yacc_d;

  // Per-transaction working registers.
  logic [17:0] summag_q, summag_d;
  logic        sdneg_q, sdneg_d, sumneg_q, sumneg_d;
  logic [48:0] a_q, a_d;
  logic [MagBits-1:0] m_q, m_d;
  logic        mneg_q, mneg_d;

  // Shift-add multiplier.
  logic [79:0] acc_q, acc_d, mcd_q, mcd_d, acc_step;
  logic [39:0] mpl_q, mpl_d;

  // CORDIC stage.
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic signed [33:0] xs, ys, at, cx_n, cy_n, cz_n, cz_init;
  logic        flip_q, flip_d, flip_init, cord_load;
  logic [31:0] cord_ang, ang_adj;
  logic signed [31:0] c_q, c_d, s_q, s_d;

  ddo_state_e  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  ddo_out_t    out_q, out_d;
  logic        outv_q, outv_d;

  logic        in_acc;
  logic [31:0] dl_raw, dr_raw, inc;
  logic signed [17:0] dl, dr, sd, sm;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;

  // A change passes only when its magnitude lies strictly between the limits;
  // a passing change is below 2^16, so its low 18 bits carry it with its sign.
  function automatic logic signed [17:0] gate(input logic [31:0] d, input logic [15:0] lo,
                                              input logic [15:0] hi);
    logic [31:0] mag;
    mag = d[31] ? (32'd0 - d) : d;
    if (mag > {16'd0, lo} && mag < {16'd0, hi}) return d[17:0];
    return 18'sd0;
  endfunction

  function automatic logic signed [31:0] fin(input logic signed [33:0] v, input logic f);
    logic signed [31:0] r;
    if (v > 34'sh040000000) r = 32'sh40000000;
    else if (v < -34'sh040000000) r = -32'sh40000000;
    else r = v[31:0];
    return f ? -r : r;
  endfunction

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] acc,
                                                 input logic [MagBits-1:0] m,
                                                 input logic neg);
    logic signed [51:0] st, r;
    st = $signed({{(52 - MagBits){1'b0}}, m});
    r  = {{4{acc[47]}}, acc} + (neg ? -st : st);
    if (r > 52'sh0007FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
    if (r < -52'sh0000800000000000) return 48'sh800000000000;
    return r[47:0];
  endfunction

  assign dl_raw = in_data_i.left_position - lprev_q;
  assign dr_raw = in_data_i.right_position - rprev_q;
  assign dl = gate(dl_raw, min_q, max_q);
  assign dr = gate(dr_raw, min_q, max_q);
  assign sd = dl - dr;
  assign sm = dl + dr;

  assign acc_step = acc_q + (mpl_q[0] ? mcd_q : 80'd0);
  assign inc      = acc_step[63:32];

  // One CORDIC rotation per cycle.
  assign xs   = cx_q >>> cnt_q[4:0];
  assign ys   = cy_q >>> cnt_q[4:0];
  assign at   = $signed({2'b00, ddo_atan(cnt_q[4:0])});
  assign cx_n = cz_q[33] ? cx_q + ys : cx_q - ys;
  assign cy_n = cz_q[33] ? cy_q - xs : cy_q + xs;
  assign cz_n = cz_q[33] ? cz_q + at : cz_q - at;

  // Angles past a quarter turn are rotated by a half turn; the result is negated later.
  assign ang_adj   = cord_ang + 32'h40000000;
  assign flip_init = ang_adj[31];
  assign cz_init   = $signed({{2{cord_ang[31] ^ flip_init}}, cord_ang[31] ^ flip_init,
                              cord_ang[30:0]});

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q + 6'd1;
    lprev_d = lprev_q;  rprev_d = rprev_q;  heading_d = heading_q;
    xacc_d = xacc_q;    yacc_d = yacc_q;
    summag_d = summag_q;  sdneg_d = sdneg_q;  sumneg_d = sumneg_q;
    a_d = a_q;  m_d = m_q;  mneg_d = mneg_q;
    acc_d = acc_step;  mcd_d = {mcd_q[78:0], 1'b0};  mpl_d = {1'b0, mpl_q[39:1]};
    cx_d = cx_n;  cy_d = cy_n;  cz_d = cz_n;  flip_d = flip_q;
    c_d = c_q;  s_d = s_q;
    out_d = out_q;
    outv_d = outv_q && !out_ready_i;
    cord_load = 1'b0;
    cord_ang  = heading_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          lprev_d  = in_data_i.left_position;
          rprev_d  = in_data_i.right_position;
          sdneg_d  = sd[17];
          sumneg_d = sm[17];
          summag_d = sm[17] ? 18'd0 - sm : sm;
          acc_d    = '0;
          mcd_d    = {48'd0, mpp_q};
          mpl_d    = {22'd0, sd[17] ? 18'd0 - sd : sd};
          cnt_d    = '0;
          state_d  = StMulSd;
        end
      end
      StMulSd: begin
        if (cnt_q == 6'd17) begin
          acc_d = 80'd1 << 31;
          mcd_d = {31'd0, acc_step[48:0]};
          mpl_d = tg_q;
          cnt_d = '0;
          state_d = StMulHd;
        end
      end
      StMulHd: begin
        if (cnt_q == 6'd39) begin
          heading_d = sdneg_q ? heading_q - inc : heading_q + inc;
          cord_ang  = heading_d;
          cord_load = 1'b1;
          cnt_d     = '0;
          state_d   = StCord1;
        end
      end
      StCord1: begin
        if (cnt_q == 6'(CordicIters - 1)) state_d = StFin1;
      end
      StFin1: begin
        c_d = fin(cx_q, flip_q);
        s_d = fin(cy_q, flip_q);
        acc_d = '0;
        mcd_d = {48'd0, mpp_q};
        mpl_d = {22'd0, summag_q};
        cnt_d = '0;
        state_d = StMulSum;
      end
      StMulSum: begin
        if (cnt_q == 6'd17) begin
          a_d   = acc_step[48:0];
          acc_d = 80'd1 << (PosShift - 1);
          mcd_d = {31'd0, acc_step[48:0]};
          mpl_d = {8'd0, c_q[31] ? 32'd0 - c_q : c_q};
          cnt_d = '0;
          state_d = StMulX;
        end
      end
      StMulX: begin
        if (cnt_q == 6'd31) begin
          m_d    = acc_step[79:PosShift];
          mneg_d = sumneg_q ^ c_q[31];
          acc_d  = 80'd1 << (PosShift - 1);
          mcd_d  = {31'd0, a_q};
          mpl_d  = {8'd0, s_q[31] ? 32'd0 - s_q : s_q};
          cnt_d  = '0;
          state_d = StMulY;
        end
      end
      StMulY: begin
        // The x step from the previous product is folded in while y is multiplied.
        if (cnt_q == 6'd0) xacc_d = sat_add(xacc_q, m_q, mneg_q);
        if (cnt_q == 6'd31) begin
          m_d    = acc_step[79:PosShift];
          mneg_d = sumneg_q ^ s_q[31];
          state_d = StYUpd;
        end
      end
      StYUpd: begin
        yacc_d    = sat_add(yacc_q, m_q, mneg_q);
        cord_ang  = {1'b0, heading_q[31:1]};
        cord_load = 1'b1;
        cnt_d     = '0;
        state_d   = StCord2;
      end
      StCord2: begin
        if (cnt_q == 6'(CordicIters - 1)) state_d = StFin2;
      end
      StFin2: begin
        c_d = fin(cx_q, flip_q);
        s_d = fin(cy_q, flip_q);
        state_d = StDone;
      end
      StDone: begin
        if (!outv_q || out_ready_i) begin
          out_d.x_pos   = xacc_q;
          out_d.y_pos   = yacc_q;
          out_d.heading = heading_q;
          out_d.quat_z  = s_q;
          out_d.quat_w  = c_q;
          outv_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (cord_load) begin
      cx_d = CordicX0;
      cy_d = '0;
      cz_d = cz_init;
      flip_d = flip_init;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpp_q <= 32'd65536;
      min_q <= 16'd0;
      max_q <= 16'd15000;
      tg_q  <= 40'd2278000000;
      state_q <= StIdle;
      cnt_q <= '0;
      outv_q <= 1'b0;
      lprev_q <= '0;
      rprev_q <= '0;
      heading_q <= '0;
      xacc_q <= '0;
      yacc_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (ddo_cfg_e'(cfg_index_i))
          CfgMetersPerPulse: mpp_q <= cfg_data_i[31:0];
          CfgMinCount:       min_q <= cfg_data_i[15:0];
          CfgMaxCount:       max_q <= cfg_data_i[15:0];
          CfgTurnGain:       tg_q  <= cfg_data_i;
          default: ;
        endcase
      end
      state_q <= state_d;
      cnt_q <= cnt_d;
      outv_q <= outv_d;
      lprev_q <= lprev_d;
      rprev_q <= rprev_d;
      heading_q <= heading_d;
      xacc_q <= xacc_d;
      yacc_q <= yacc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    summag_q <= summag_d;  sdneg_q <= sdneg_d;  sumneg_q <= sumneg_d;
    a_q <= a_d;  m_q <= m_d;  mneg_q <= mneg_d;
    acc_q <= acc_d;  mcd_q <= mcd_d;  mpl_q <= mpl_d;
    cx_q <= cx_d;  cy_q <= cy_d;  cz_q <= cz_d;  flip_q <= flip_d;
    c_q <= c_d;  s_q <= s_d;
    out_q <= out_d;
  end

  // The heading moves only at the end of the turn product.
  a_heading_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(heading_q) |-> $past(state_q) == StMulHd)
    else $error("heading changed outside the turn update");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == StMulSd)
    else $error("accepted transaction did not start the sequencer");

  a_cord_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCord1 || state_q == StCord2) |-> cnt_q < 6'(CordicIters))
    else $error("CORDIC ran past its iteration count");

  // Both quaternion terms are clamped to one in Q1.30.
  a_quat_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.quat_z <= 32'sh40000000 &&
                    out_data_o.quat_z >= -32'sh40000000 &&
                    out_data_o.quat_w <= 32'sh40000000 &&
                    out_data_o.quat_w >= -32'sh40000000)
    else $error("quaternion term out of range");

endmodule
